// ===== hw/rtl/qla_pkg.sv =====
package qla_pkg;

    localparam int OUT_W      = 16;
    localparam int FRAC_BITS  = 28;
    localparam int SCALE_W    = 15;
    localparam int N_STAGES   = 10;

    // widths of the exact intermediate sums that get truncated
    localparam int LIN_NUM_W  = 51;
    localparam int WD_W       = 54;

    localparam logic [SCALE_W-1:0]     GRAVITY_SCALE_RESET = 15'd970;
    localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

    typedef logic signed [OUT_W-1:0] t_sample;

endpackage

// ===== hw/rtl/qla_trunc_sat.sv =====
module qla_trunc_sat
    import qla_pkg::*;
#(
    parameter int IN_W = LIN_NUM_W
) (
    input  logic signed [IN_W-1:0] i_num,
    output t_sample                o_val,
    output logic                   o_clip
);

    localparam int Q_W = IN_W + 1 - FRAC_BITS;
    localparam logic signed [IN_W:0] BIAS = (IN_W+1)'((64'd1 << FRAC_BITS) - 64'd1);

    logic signed [IN_W:0]  biased;
    logic signed [Q_W-1:0] quot;
    logic                  ovf;

    always_comb begin
        // bias negative values so the arithmetic shift rounds toward zero
        biased = (IN_W+1)'(i_num) + (i_num[IN_W-1] ? BIAS : '0);
        quot   = biased[IN_W:FRAC_BITS];
        ovf    = !((&quot[Q_W-1:OUT_W-1]) || !(|quot[Q_W-1:OUT_W-1]));
        if (ovf) begin
            o_val = quot[Q_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            o_val = quot[OUT_W-1:0];
        end
        o_clip = ovf;
    end

endmodule

// ===== hw/rtl/quaternion_linear_accel_to_world.sv =====
// Linear acceleration to world frame.
// Input channel: i_valid / o_stall carry one quaternion (Q2.14) and one raw
// accelerometer sample per transaction. Output channel: o_valid / i_stall carry
// the gravity-free sensor-frame vector, its rotation q*p*conj(q) into the world
// frame and a flag that is set when any of the six components saturated.
// A transaction moves at a rising edge with valid high and stall low.
// The ten register stages accept one transaction per cycle while o_stall is
// low; the depth is set by the two multiply rounds of the gravity path and the
// two of the rotation.
// i_gravity_scale is written when i_gravity_scale_we is high; write it only
// while no transaction is in flight.
// Reset (synchronous, active low) empties the pipeline and loads the scale
// with 970. When the receiver stalls, the last stage holds its result and
// stages behind it keep advancing into empty slots; o_stall rises only once
// every stage is occupied.
module quaternion_linear_accel_to_world
    import qla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_gravity_scale_we,
    input  logic [SCALE_W-1:0] i_gravity_scale,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_sample            i_quat_w,
    input  t_sample            i_quat_x,
    input  t_sample            i_quat_y,
    input  t_sample            i_quat_z,
    input  t_sample            i_raw_accel_x,
    input  t_sample            i_raw_accel_y,
    input  t_sample            i_raw_accel_z,
    output logic               o_valid,
    input  logic               i_stall,
    output t_sample            o_lin_accel_x,
    output t_sample            o_lin_accel_y,
    output t_sample            o_lin_accel_z,
    output t_sample            o_world_accel_x,
    output t_sample            o_world_accel_y,
    output t_sample            o_world_accel_z,
    output logic               o_clipped
);

    localparam int PROD_W = 32;
    localparam int G_W    = 34;
    localparam int K_W    = 33;
    localparam int GS_W   = 50;
    localparam int KV_W   = 49;
    localparam int DOT_W  = 34;
    localparam int C_W    = 33;
    localparam int TD_W   = 51;
    localparam int TC_W   = 50;

    logic [SCALE_W-1:0]  r_scale;
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] en;

    // stage 0: quaternion products
    t_sample                  r_s0_q [4];
    t_sample                  r_s0_raw [3];
    logic signed [PROD_W-1:0] r_s0_pww, r_s0_pxx, r_s0_pyy, r_s0_pzz;
    logic signed [PROD_W-1:0] r_s0_pxz, r_s0_pwy, r_s0_pwx, r_s0_pyz;
    // stage 1: gravity direction and k0
    t_sample                  r_s1_q [4];
    t_sample                  r_s1_raw [3];
    logic signed [G_W-1:0]    r_s1_g [3];
    logic signed [K_W-1:0]    r_s1_k0;
    // stage 2: gravity times scale
    t_sample                  r_s2_q [4];
    t_sample                  r_s2_raw [3];
    logic signed [GS_W-1:0]   r_s2_gs [3];
    logic signed [K_W-1:0]    r_s2_k0;
    // stage 3: exact linear numerator
    t_sample                  r_s3_q [4];
    logic signed [LIN_NUM_W-1:0] r_s3_num [3];
    logic signed [K_W-1:0]    r_s3_k0;
    // stage 4: saturated linear vector
    t_sample                  r_s4_q [4];
    t_sample                  r_s4_lin [3];
    logic signed [K_W-1:0]    r_s4_k0;
    logic                     r_s4_clip;
    // stage 5: rotation products
    t_sample                  r_s5_w;
    t_sample                  r_s5_u [3];
    t_sample                  r_s5_lin [3];
    logic                     r_s5_clip;
    logic signed [PROD_W-1:0] r_s5_pd [3];
    logic signed [PROD_W-1:0] r_s5_pc [6];
    logic signed [KV_W-1:0]   r_s5_kv [3];
    // stage 6: dot and cross products
    t_sample                  r_s6_w;
    t_sample                  r_s6_u [3];
    t_sample                  r_s6_lin [3];
    logic                     r_s6_clip;
    logic signed [DOT_W-1:0]  r_s6_dot;
    logic signed [C_W-1:0]    r_s6_c [3];
    logic signed [KV_W-1:0]   r_s6_kv [3];
    // stage 7: scaled terms
    t_sample                  r_s7_lin [3];
    logic                     r_s7_clip;
    logic signed [TD_W-1:0]   r_s7_td [3];
    logic signed [TC_W-1:0]   r_s7_tc [3];
    logic signed [KV_W-1:0]   r_s7_kv [3];
    // stage 8: exact world numerator
    t_sample                  r_s8_lin [3];
    logic                     r_s8_clip;
    logic signed [WD_W-1:0]   r_s8_wd [3];
    // stage 9: output register
    t_sample                  r_s9_lin [3];
    t_sample                  r_s9_world [3];
    logic                     r_s9_clip;

    t_sample    lin_val [3];
    logic [2:0] lin_clip;
    t_sample    world_val [3];
    logic [2:0] world_clip;

    // a stage may load when it is empty or its successor loads
    always_comb begin
        en[N_STAGES-1] = !r_v[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_scale <= GRAVITY_SCALE_RESET;
        end else begin
            if (i_gravity_scale_we) begin
                r_scale <= i_gravity_scale;
            end
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_q   <= '{i_quat_w, i_quat_x, i_quat_y, i_quat_z};
            r_s0_raw <= '{i_raw_accel_x, i_raw_accel_y, i_raw_accel_z};
            r_s0_pww <= PROD_W'(i_quat_w) * PROD_W'(i_quat_w);
            r_s0_pxx <= PROD_W'(i_quat_x) * PROD_W'(i_quat_x);
            r_s0_pyy <= PROD_W'(i_quat_y) * PROD_W'(i_quat_y);
            r_s0_pzz <= PROD_W'(i_quat_z) * PROD_W'(i_quat_z);
            r_s0_pxz <= PROD_W'(i_quat_x) * PROD_W'(i_quat_z);
            r_s0_pwy <= PROD_W'(i_quat_w) * PROD_W'(i_quat_y);
            r_s0_pwx <= PROD_W'(i_quat_w) * PROD_W'(i_quat_x);
            r_s0_pyz <= PROD_W'(i_quat_y) * PROD_W'(i_quat_z);
        end
        if (en[1]) begin
            r_s1_q    <= r_s0_q;
            r_s1_raw  <= r_s0_raw;
            r_s1_g[0] <= (G_W'(r_s0_pxz) - G_W'(r_s0_pwy)) <<< 1;
            r_s1_g[1] <= (G_W'(r_s0_pwx) + G_W'(r_s0_pyz)) <<< 1;
            r_s1_g[2] <= G_W'(r_s0_pww) - G_W'(r_s0_pxx) - G_W'(r_s0_pyy)
                       + G_W'(r_s0_pzz);
            r_s1_k0   <= K_W'(r_s0_pww) - K_W'(r_s0_pxx) - K_W'(r_s0_pyy)
                       - K_W'(r_s0_pzz);
        end
        if (en[2]) begin
            r_s2_q   <= r_s1_q;
            r_s2_raw <= r_s1_raw;
            r_s2_k0  <= r_s1_k0;
            for (int i = 0; i < 3; i++) begin
                r_s2_gs[i] <= GS_W'(r_s1_g[i]) * GS_W'($signed({1'b0, r_scale}));
            end
        end
        if (en[3]) begin
            r_s3_q  <= r_s2_q;
            r_s3_k0 <= r_s2_k0;
            for (int i = 0; i < 3; i++) begin
                r_s3_num[i] <= LIN_NUM_W'($signed({r_s2_raw[i], {FRAC_BITS{1'b0}}}))
                             - LIN_NUM_W'(r_s2_gs[i]);
            end
        end
        if (en[4]) begin
            r_s4_q    <= r_s3_q;
            r_s4_k0   <= r_s3_k0;
            r_s4_lin  <= lin_val;
            r_s4_clip <= |lin_clip;
        end
        if (en[5]) begin
            r_s5_w    <= r_s4_q[0];
            r_s5_u    <= '{r_s4_q[1], r_s4_q[2], r_s4_q[3]};
            r_s5_lin  <= r_s4_lin;
            r_s5_clip <= r_s4_clip;
            for (int i = 0; i < 3; i++) begin
                r_s5_pd[i] <= PROD_W'(r_s4_q[i+1]) * PROD_W'(r_s4_lin[i]);
                r_s5_kv[i] <= KV_W'(r_s4_k0) * KV_W'(r_s4_lin[i]);
            end
            // cross product terms, minuend then subtrahend per axis
            r_s5_pc[0] <= PROD_W'(r_s4_q[2]) * PROD_W'(r_s4_lin[2]);
            r_s5_pc[1] <= PROD_W'(r_s4_q[3]) * PROD_W'(r_s4_lin[1]);
            r_s5_pc[2] <= PROD_W'(r_s4_q[3]) * PROD_W'(r_s4_lin[0]);
            r_s5_pc[3] <= PROD_W'(r_s4_q[1]) * PROD_W'(r_s4_lin[2]);
            r_s5_pc[4] <= PROD_W'(r_s4_q[1]) * PROD_W'(r_s4_lin[1]);
            r_s5_pc[5] <= PROD_W'(r_s4_q[2]) * PROD_W'(r_s4_lin[0]);
        end
        if (en[6]) begin
            r_s6_w    <= r_s5_w;
            r_s6_u    <= r_s5_u;
            r_s6_lin  <= r_s5_lin;
            r_s6_clip <= r_s5_clip;
            r_s6_kv   <= r_s5_kv;
            r_s6_dot  <= DOT_W'(r_s5_pd[0]) + DOT_W'(r_s5_pd[1]) + DOT_W'(r_s5_pd[2]);
            for (int i = 0; i < 3; i++) begin
                r_s6_c[i] <= C_W'(r_s5_pc[2*i]) - C_W'(r_s5_pc[2*i+1]);
            end
        end
        if (en[7]) begin
            r_s7_lin  <= r_s6_lin;
            r_s7_clip <= r_s6_clip;
            r_s7_kv   <= r_s6_kv;
            for (int i = 0; i < 3; i++) begin
                r_s7_td[i] <= (TD_W'(r_s6_dot) * TD_W'(r_s6_u[i])) <<< 1;
                r_s7_tc[i] <= (TC_W'(r_s6_c[i]) * TC_W'(r_s6_w)) <<< 1;
            end
        end
        if (en[8]) begin
            r_s8_lin  <= r_s7_lin;
            r_s8_clip <= r_s7_clip;
            for (int i = 0; i < 3; i++) begin
                r_s8_wd[i] <= WD_W'(r_s7_kv[i]) + WD_W'(r_s7_td[i]) + WD_W'(r_s7_tc[i]);
            end
        end
        if (en[9]) begin
            r_s9_lin   <= r_s8_lin;
            r_s9_world <= world_val;
            r_s9_clip  <= r_s8_clip || (|world_clip);
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_sat
        qla_trunc_sat #(
            .IN_W (LIN_NUM_W)
        ) u_lin_sat (
            .i_num  (r_s3_num[gi]),
            .o_val  (lin_val[gi]),
            .o_clip (lin_clip[gi])
        );

        qla_trunc_sat #(
            .IN_W (WD_W)
        ) u_world_sat (
            .i_num  (r_s8_wd[gi]),
            .o_val  (world_val[gi]),
            .o_clip (world_clip[gi])
        );
    end

    assign o_valid         = r_v[N_STAGES-1];
    assign o_lin_accel_x   = r_s9_lin[0];
    assign o_lin_accel_y   = r_s9_lin[1];
    assign o_lin_accel_z   = r_s9_lin[2];
    assign o_world_accel_x = r_s9_world[0];
    assign o_world_accel_y = r_s9_world[1];
    assign o_world_accel_z = r_s9_world[2];
    assign o_clipped       = r_s9_clip;

    // input side only backs up once every stage holds a transaction
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_v))
        else $error("input stalled with an empty stage");

    // a flagged result carries at least one rail value
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_lin_accel_x == SAT_MAX || o_lin_accel_x == SAT_MIN ||
             o_lin_accel_y == SAT_MAX || o_lin_accel_y == SAT_MIN ||
             o_lin_accel_z == SAT_MAX || o_lin_accel_z == SAT_MIN ||
             o_world_accel_x == SAT_MAX || o_world_accel_x == SAT_MIN ||
             o_world_accel_y == SAT_MAX || o_world_accel_y == SAT_MIN ||
             o_world_accel_z == SAT_MAX || o_world_accel_z == SAT_MIN))
        else $error("clip flag set without a saturated component");

    a_scale_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_gravity_scale_we |=> (r_scale == $past(i_gravity_scale)))
        else $error("gravity scale write lost");

    // a held result may not be overwritten by the stage behind it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[N_STAGES-1] && i_stall) |=> (r_v[N_STAGES-1] && $stable(r_s9_world[0])))
        else $error("stalled output overwritten");

endmodule
